/* sv/lkvc_pkg.sv */
package lkvc_pkg;

  // default table size and the rank width that goes with it
  localparam int DEF_ENTRIES = 16;
  localparam int DEF_RANK_W  = $clog2(DEF_ENTRIES);

  // capacity register
  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  // word widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // value returned by a get that misses
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // what every cell does in the current cycle
  typedef enum logic [2:0] {
    CM_IDLE,
    CM_CMP,
    CM_HIT,
    CM_FILL,
    CM_EVICT,
    CM_CLEAR
  } cell_mode_t;

  // broadcast from the controller to the row of cells
  typedef struct packed {
    cell_mode_t       mode;
    logic             put;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

  // handed from each cell to its right-hand neighbour
  typedef struct packed {
    logic             free_seen;
    logic             hit;
    logic [VAL_W-1:0] value;
  } link_t;

  // controller sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

endpackage

/* sv/lru_key_value_cache.sv */
// a word is accepted into the input registers, its key is compared in all cells, then the update
// writes the result word to the output register; no new word is taken until that update is done
// a result waiting on out_stall holds the update; the next word is taken once it is out
// reset (rst_n low, synchronous): table empty, capacity 16, no word in flight
// a capacity write clears the table in the same cycle
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [4:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_value
);
  import lkvc_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t           state_r, state_nxt;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_value_r;

  logic              accept;
  logic              out_free;
  logic              commit;
  logic              fill_ok;
  logic [CMP_W-1:0]  used_ext;
  logic [CMP_W-1:0]  cap_min;
  logic [CNT_W-1:0]  used_dec;
  logic [RANK_W-1:0] lru_rank;
  logic [RANK_W-1:0] promo_rank;
  cell_mode_t        upd_mode;
  cell_cmd_t         cmd;
  logic [VAL_W-1:0]  result_value;

  link_t             links [ENTRIES+1];
  logic [RANK_W-1:0] ranks [ENTRIES+1];

  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // row of cells, chained left to right
  assign links[0] = '0;
  assign ranks[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .RANK_W(RANK_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .promo_rank (promo_rank),
      .link_in    (links[i]),
      .rank_in    (ranks[i]),
      .link_out   (links[i+1]),
      .rank_out   (ranks[i+1])
    );
  end

  // room for a new entry: below both the table size and the clamped capacity
  assign used_ext = CMP_W'(used_r);
  assign cap_min  = (cap_r == '0) ? CMP_W'(1) : CMP_W'(cap_r);
  assign fill_ok  = (used_ext < CMP_W'(ENTRIES)) && (used_ext < cap_min);

  // least recent entry holds rank used-1
  assign used_dec   = used_r - 1'b1;
  assign lru_rank   = used_dec[RANK_W-1:0];
  assign promo_rank = links[ENTRIES].hit ? ranks[ENTRIES] : lru_rank;

  // update chosen from the compare result
  always_comb begin
    if (links[ENTRIES].hit) begin
      upd_mode = CM_HIT;
    end else if (!op_r) begin
      upd_mode = CM_IDLE;
    end else if (fill_ok) begin
      upd_mode = CM_FILL;
    end else begin
      upd_mode = CM_EVICT;
    end
  end

  // result word
  always_comb begin
    if (op_r) begin
      result_value = '0;
    end else if (links[ENTRIES].hit) begin
      result_value = links[ENTRIES].value;
    end else begin
      result_value = MISS_VALUE;
    end
  end

  // next state
  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = in_valid ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = out_free ? ST_IDLE : ST_UPD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs: cell command and commit
  always_comb begin
    commit    = 1'b0;
    cmd.put   = op_r;
    cmd.key   = key_r;
    cmd.value = value_r;
    cmd.mode  = CM_IDLE;
    case (state_r)
      ST_CMP: begin
        cmd.mode = CM_CMP;
      end
      ST_UPD: begin
        if (out_free) begin
          commit   = 1'b1;
          cmd.mode = upd_mode;
        end
      end
      default: begin
        cmd.mode = CM_IDLE;
      end
    endcase
    if (cfg_write_en) begin
      cmd.mode = CM_CLEAR;
    end
  end

  // fill count
  always_comb begin
    used_nxt = used_r;
    if (cfg_write_en) begin
      used_nxt = '0;
    end else if (commit && (upd_mode == CM_FILL)) begin
      used_nxt = used_r + 1'b1;
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        cap_r <= cfg_write_data;
      end
    end
  end

  // captured word and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      key_r   <= in_lookup_key;
      value_r <= in_write_value;
    end
    if (commit) begin
      out_hit_r   <= links[ENTRIES].hit;
      out_value_r <= result_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

endmodule

/* sv/lkvc_cell.sv */
module lkvc_cell #(
  parameter int RANK_W = lkvc_pkg::DEF_RANK_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lkvc_pkg::cell_cmd_t cmd,
  input  logic [RANK_W-1:0]   promo_rank,
  input  lkvc_pkg::link_t     link_in,
  input  logic [RANK_W-1:0]   rank_in,
  output lkvc_pkg::link_t     link_out,
  output logic [RANK_W-1:0]   rank_out
);
  import lkvc_pkg::*;

  logic              valid_r, valid_nxt;
  logic              match_r, match_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;

  logic fill_here;
  logic sel;
  logic age;

  // this cell is the lowest free slot when no cell to the left is free
  assign fill_here = !valid_r && !link_in.free_seen;

  // chain to the neighbour: free flag, and the one matching word and rank
  assign link_out.free_seen = link_in.free_seen | !valid_r;
  assign link_out.hit       = link_in.hit | match_r;
  assign link_out.value     = link_in.value | ({VAL_W{match_r}} & value_r);
  assign rank_out           = rank_in | ({RANK_W{match_r}} & rank_r);

  // selection of the entry that becomes most recent
  always_comb begin
    case (cmd.mode)
      CM_HIT:   sel = match_r;
      CM_FILL:  sel = fill_here;
      CM_EVICT: sel = valid_r && (rank_r == promo_rank);
      default:  sel = 1'b0;
    endcase
  end

  // ageing of the other entries
  always_comb begin
    case (cmd.mode)
      CM_FILL:          age = valid_r;
      CM_HIT, CM_EVICT: age = valid_r && !sel && (rank_r < promo_rank);
      default:          age = 1'b0;
    endcase
  end

  // next cell state
  always_comb begin
    valid_nxt = valid_r;
    match_nxt = match_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    case (cmd.mode)
      CM_CLEAR: begin
        valid_nxt = 1'b0;
        match_nxt = 1'b0;
        rank_nxt  = '0;
      end
      CM_CMP: begin
        match_nxt = valid_r && (key_r == cmd.key);
      end
      CM_HIT, CM_FILL, CM_EVICT: begin
        if (sel) begin
          valid_nxt = 1'b1;
          rank_nxt  = '0;
          if (cmd.mode != CM_HIT) begin
            key_nxt = cmd.key;
          end
          if (cmd.put) begin
            value_nxt = cmd.value;
          end
        end else if (age) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // stored key and value
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

/* tb/lru_cache_checker.sv */
package lru_tb_pkg;

  // access kinds carried by the operation bit
  typedef enum logic {
    ACC_GET = 1'b0,
    ACC_PUT = 1'b1
  } access_op_t;

  // one result word as the cache should return it
  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } reply_t;

endpackage

module lru_cache_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [4:0]         cfg_write_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_write_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic signed [31:0] out_read_value,
  output int                 mismatch_count,
  output int                 replies_outstanding,
  output int                 replies_checked,
  output int                 hits_predicted,
  output int                 evictions_predicted
);
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;
  import lru_tb_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int RANK_W  = DEF_RANK_W;
  localparam int SHOWN   = 50;

  // shadow copy of the table
  logic                line_valid [ENTRIES];
  logic [KEY_W-1:0]    line_key   [ENTRIES];
  logic [VAL_W-1:0]    line_value [ENTRIES];
  logic [RANK_W-1:0]   line_rank  [ENTRIES];
  logic [CAP_W-1:0]    lines_used;
  logic [CAP_W-1:0]    capacity;

  // results still owed by the cache, oldest first
  reply_t replies_due [$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // empty table, as after reset or a capacity write
  function automatic void wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_value[i] = '0;
      line_rank[i]  = '0;
    end
    lines_used = '0;
  endfunction

  // line s becomes newest, every newer line ages by one
  function automatic void make_newest(input int s);
    logic [RANK_W-1:0] age;
    age = line_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] < age) line_rank[i]++;
    end
    line_rank[s] = '0;
  endfunction

  // one get or put against the shadow table
  function automatic reply_t lru_access(input access_op_t op, input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] data);
    reply_t            reply;
    int                found;
    int                target;
    logic [CAP_W-1:0]  room;
    logic [RANK_W-1:0] oldest;
    found  = -1;
    target = -1;
    room   = capacity;
    if (room == '0) room = CAP_W'(1);
    if (room > CAP_W'(ENTRIES)) room = CAP_W'(ENTRIES);
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
    end
    reply.hit        = (found >= 0);
    reply.read_value = '0;
    if (found >= 0) begin
      if (op == ACC_GET) reply.read_value = line_value[found];
      else line_value[found] = data;
      make_newest(found);
    end else if (op == ACC_GET) begin
      reply.read_value = MISS_VALUE;
    end else begin
      // fill the lowest free line while below capacity
      if (lines_used < room) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (target < 0 && !line_valid[i]) target = i;
        end
      end
      if (target >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i]) line_rank[i]++;
        end
        lines_used++;
      end else begin
        // replace the oldest line
        oldest = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && (target < 0 || line_rank[i] > oldest)) begin
            target = i;
            oldest = line_rank[i];
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && i != target) line_rank[i]++;
        end
        evictions_predicted++;
      end
      line_valid[target] = 1'b1;
      line_key[target]   = key;
      line_value[target] = data;
      line_rank[target]  = '0;
    end
    return reply;
  endfunction

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    reply_t due;
    reply_t fresh;
    if (!rst_n) begin
      wipe_table();
      capacity = CAP_RESET;
      replies_due.delete();
      mismatch_count      = 0;
      replies_checked     = 0;
      hits_predicted      = 0;
      evictions_predicted = 0;
    end else begin
      if (cfg_write_en) begin
        capacity = cfg_write_data;
        wipe_table();
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result word hit=%0b value=%h with nothing expected",
                                    out_hit, out_read_value));
        end else begin
          due = replies_due.pop_front();
          replies_checked++;
          if (out_hit !== due.hit) begin
            report_mismatch($sformatf("hit %0b, expected %0b", out_hit, due.hit));
          end
          if (out_read_value !== due.read_value) begin
            report_mismatch($sformatf("read_value %h, expected %h",
                                      out_read_value, due.read_value));
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh = lru_access(access_op_t'(in_operation), in_lookup_key, in_write_value);
        if (fresh.hit) hits_predicted++;
        replies_due.push_back(fresh);
      end
    end
    replies_outstanding = replies_due.size();
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lru_tb_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 128;
  localparam int HOLD_CYCLES   = 80;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;

  logic               clk;
  logic               rst_n;
  logic               cfg_write_en;
  logic [4:0]         cfg_write_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_operation;
  logic signed [31:0] in_lookup_key;
  logic signed [31:0] in_write_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic signed [31:0] out_read_value;

  int mismatch_count;
  int replies_outstanding;
  int replies_checked;
  int hits_predicted;
  int evictions_predicted;

  // stimulus control shared with the receiver
  logic idling_on;
  logic hold_asked;
  int   quiet_cycles;
  int   settings_used;

  logic [4:0]  phase_cap [PHASES];
  logic [31:0] key_pool  [24];

  lru_key_value_cache u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

  lru_cache_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_write_data      (cfg_write_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_lookup_key       (in_lookup_key),
    .in_write_value      (in_write_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .mismatch_count      (mismatch_count),
    .replies_outstanding (replies_outstanding),
    .replies_checked     (replies_checked),
    .hits_predicted      (hits_predicted),
    .evictions_predicted (evictions_predicted)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word from a falling edge and return at the falling edge after it is taken
  task automatic offer_access(input access_op_t op, input logic [31:0] key,
                              input logic [31:0] data);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_lookup_key  <= key;
    in_write_value <= data;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  // wait for every owed result, let the cache settle, then write capacity
  task automatic settle_and_configure(input logic [4:0] cap);
    in_valid <= 1'b0;
    while (replies_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= cap;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    settings_used++;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin : receiver
    logic held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= idling_on && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int          room;
    int          pool_size;
    logic [31:0] key;
    access_op_t  op;
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    in_operation   = ACC_GET;
    in_lookup_key  = '0;
    in_write_value = '0;
    idling_on      = 1'b1;
    hold_asked     = 1'b0;
    settings_used  = 1;
    phase_cap      = '{5'd31, 5'd3, 5'd16, 5'd1, 5'd17, 5'd0, 5'd8, 5'd5};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: extreme keys and values, miss on empty, update, stored -1
    offer_access(ACC_GET, 32'h0000_0000, $urandom);
    offer_access(ACC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_access(ACC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_access(ACC_PUT, 32'h0000_0000, 32'h0000_0000);
    offer_access(ACC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_access(ACC_GET, 32'hFFFF_FFFF, $urandom);
    offer_access(ACC_GET, 32'h8000_0000, $urandom);
    offer_access(ACC_PUT, 32'h0000_0000, 32'h1234_5678);
    offer_access(ACC_GET, 32'h0000_0000, $urandom);
    offer_access(ACC_GET, 32'h0000_0005, $urandom);

    // capacity write clears the table, then eviction of the older of two
    settle_and_configure(5'd2);
    offer_access(ACC_GET, 32'h8000_0000, $urandom);
    offer_access(ACC_PUT, 32'h0000_0001, 32'hAAAA_5555);
    offer_access(ACC_PUT, 32'h0000_0002, 32'h5555_AAAA);
    offer_access(ACC_GET, 32'h0000_0001, $urandom);
    offer_access(ACC_PUT, 32'h0000_0003, 32'h0F0F_F0F0);
    offer_access(ACC_GET, 32'h0000_0002, $urandom);
    offer_access(ACC_GET, 32'h0000_0001, $urandom);
    offer_access(ACC_GET, 32'h0000_0003, $urandom);

    // capacity zero behaves as one
    settle_and_configure(5'd0);
    offer_access(ACC_PUT, 32'h0000_0007, 32'hDEAD_0007);
    offer_access(ACC_PUT, 32'h0000_0008, 32'hDEAD_0008);
    offer_access(ACC_GET, 32'h0000_0007, $urandom);
    offer_access(ACC_GET, 32'h0000_0008, $urandom);

    // random phases, each under its own capacity
    for (int p = 0; p < PHASES; p++) begin
      settle_and_configure(phase_cap[p]);
      idling_on = (p != 1);
      room = int'(phase_cap[p]);
      if (room == 0) room = 1;
      if (room > 16) room = 16;
      pool_size = room + $urandom_range(1, 5);
      for (int i = 0; i < pool_size; i++) begin
        case ($urandom_range(0, 15))
          0:       key_pool[i] = 32'h0000_0000;
          1:       key_pool[i] = 32'hFFFF_FFFF;
          2:       key_pool[i] = 32'h8000_0000;
          3:       key_pool[i] = 32'h7FFF_FFFF;
          default: key_pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) hold_asked = 1'b1;
        // mostly keys from the working set, some stray keys
        if ($urandom_range(0, 99) < 90) key = key_pool[$urandom_range(0, pool_size - 1)];
        else key = $urandom;
        op = ($urandom_range(0, 99) < 45) ? ACC_PUT : ACC_GET;
        offer_access(op, key, $urandom);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (replies_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d accesses, %0d hits and %0d evictions under %0d capacity settings",
             replies_checked, hits_predicted, evictions_predicted, settings_used);
    $display("including capacity 0, 1, 16 and 31 and one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lkvc_pkg.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache.sv
tb/lru_cache_checker.sv
tb/tb_top.sv
